// ===== design/epaper_refresh_wait_controller_core_assert.svh =====
// ----------------------------------------------------------------------------
// epaper refresh wait controller assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef EPAPER_REFRESH_WAIT_CONTROLLER_CORE_ASSERT_SVH
`define EPAPER_REFRESH_WAIT_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication
`define ERWC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ERWC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/erwc_pkg.sv =====
// ----------------------------------------------------------------------------
// erwc_pkg
// types and constants of the e-paper refresh wait controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package erwc_pkg;

   localparam int TIMER_BITS_DEF = 26;
   localparam int CFG_BITS       = 26;
   localparam int CSR_ADDR_BITS  = 5;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_IDX_BITS   = 3;

   localparam logic [CFG_BITS-1:0] BUSY_ASSERT_LIMIT_RST = 26'd2000000;
   localparam logic [CFG_BITS-1:0] REFRESH_LIMIT_RST     = 26'd60000000;
   localparam logic [CFG_BITS-1:0] FALLBACK_DELAY_RST    = 26'd30000000;
   localparam logic [CFG_BITS-1:0] POWER_OFF_SETTLE_RST  = 26'd100000;
   localparam logic [CFG_BITS-1:0] POWER_OFF_LIMIT_RST   = 26'd30000000;

   localparam logic [CSR_IDX_BITS-1:0] CSR_BUSY_ASSERT_LIMIT = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REFRESH_LIMIT     = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FALLBACK_DELAY    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_POWER_OFF_SETTLE  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_POWER_OFF_LIMIT   = 3'd4;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_AWAIT_BUSY = 3'd1,
      PH_AWAIT_DONE = 3'd2,
      PH_POWER_OFF  = 3'd3,
      PH_FALLBACK   = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      CMD_TICK       = 2'd0,
      CMD_REFRESH    = 2'd1,
      CMD_SLEEP      = 2'd2,
      CMD_BOOT_POWER = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OUT_NONE     = 2'd0,
      OUT_RELEASED = 2'd1,
      OUT_TIMEOUT  = 2'd2
   } outcome_type;

endpackage

// ===== design/epaper_refresh_wait_controller_core.sv =====
// ----------------------------------------------------------------------------
// epaper_refresh_wait_controller_core
// a result beat is registered and appears in the cycle after its request is taken
// throughput: one request beat per cycle unless the result stalls, set by
// the single phase/counter update; stalled results hold, refill as drained
// reset: synchronous, phase idle, tick counter zero, limits at default values
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epaper_refresh_wait_controller_core #(
   parameter int TIMER_BITS = erwc_pkg::TIMER_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_cmd,
   input  logic                                req_busy_req,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [2:0]                          rsp_phase,
   output logic                                rsp_send_power_off,
   output logic                                rsp_send_deep_sleep,
   output logic [1:0]                          rsp_outcome,
   output logic                                rsp_refresh_fault,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [erwc_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [erwc_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [erwc_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import erwc_pkg::*;

   localparam int CMP_BITS = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

   logic [CFG_BITS-1:0]     busy_assert_limit_ff;
   logic [CFG_BITS-1:0]     refresh_limit_ff;
   logic [CFG_BITS-1:0]     fallback_delay_ff;
   logic [CFG_BITS-1:0]     power_off_settle_ff;
   logic [CFG_BITS-1:0]     power_off_limit_ff;

   phase_type               phase_ff, phase_in;
   logic [TIMER_BITS-1:0]   elapsed_ff, elapsed_in;

   logic                    rsp_valid_ff;
   phase_type               rsp_phase_ff, rsp_phase_in;
   logic                    rsp_power_off_ff, rsp_power_off_in;
   logic                    rsp_deep_sleep_ff, rsp_deep_sleep_in;
   outcome_type             rsp_outcome_ff, rsp_outcome_in;
   logic                    rsp_fault_ff, rsp_fault_in;

   logic                    req_fire;
   logic                    csr_write;
   logic [CSR_IDX_BITS-1:0] csr_idx;
   logic [TIMER_BITS-1:0]   tick_count;
   logic [CMP_BITS-1:0]     tick_wide;
   logic                    busy_assert_passed;
   logic                    refresh_passed;
   logic                    fallback_passed;
   logic                    settle_passed;
   logic                    power_off_passed;
   cmd_type                 cmd;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_ADDR_BITS-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_assert_limit_ff <= BUSY_ASSERT_LIMIT_RST;
         refresh_limit_ff     <= REFRESH_LIMIT_RST;
         fallback_delay_ff    <= FALLBACK_DELAY_RST;
         power_off_settle_ff  <= POWER_OFF_SETTLE_RST;
         power_off_limit_ff   <= POWER_OFF_LIMIT_RST;
      end else if (csr_write) begin
         unique case (csr_idx)
            CSR_BUSY_ASSERT_LIMIT: busy_assert_limit_ff <= csr_pwdata[CFG_BITS-1:0];
            CSR_REFRESH_LIMIT:     refresh_limit_ff     <= csr_pwdata[CFG_BITS-1:0];
            CSR_FALLBACK_DELAY:    fallback_delay_ff    <= csr_pwdata[CFG_BITS-1:0];
            CSR_POWER_OFF_SETTLE:  power_off_settle_ff  <= csr_pwdata[CFG_BITS-1:0];
            CSR_POWER_OFF_LIMIT:   power_off_limit_ff   <= csr_pwdata[CFG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_BUSY_ASSERT_LIMIT: csr_prdata = CSR_DATA_BITS'(busy_assert_limit_ff);
         CSR_REFRESH_LIMIT:     csr_prdata = CSR_DATA_BITS'(refresh_limit_ff);
         CSR_FALLBACK_DELAY:    csr_prdata = CSR_DATA_BITS'(fallback_delay_ff);
         CSR_POWER_OFF_SETTLE:  csr_prdata = CSR_DATA_BITS'(power_off_settle_ff);
         CSR_POWER_OFF_LIMIT:   csr_prdata = CSR_DATA_BITS'(power_off_limit_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // handshake
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign cmd       = cmd_type'(req_cmd);

   // saturating tick count and limit compares
   assign tick_count = (&elapsed_ff) ? elapsed_ff : elapsed_ff + 1'b1;
   assign tick_wide  = CMP_BITS'(tick_count);

   assign busy_assert_passed = tick_wide > CMP_BITS'(busy_assert_limit_ff);
   assign refresh_passed     = tick_wide > CMP_BITS'(refresh_limit_ff);
   assign fallback_passed    = tick_wide > CMP_BITS'(fallback_delay_ff);
   assign settle_passed      = tick_wide > CMP_BITS'(power_off_settle_ff);
   assign power_off_passed   = tick_wide > CMP_BITS'(power_off_limit_ff);

   always_comb begin
      phase_in          = phase_ff;
      elapsed_in        = elapsed_ff;
      rsp_power_off_in  = 1'b0;
      rsp_deep_sleep_in = 1'b0;
      rsp_outcome_in    = OUT_NONE;
      rsp_fault_in      = 1'b0;
      unique case (cmd)
         CMD_TICK: begin
            elapsed_in = tick_count;
            unique case (phase_ff)
               PH_IDLE: ;
               PH_AWAIT_BUSY: begin
                  if (req_busy_req) begin
                     phase_in   = PH_AWAIT_DONE;
                     elapsed_in = '0;
                  end else if (busy_assert_passed) begin
                     phase_in   = PH_FALLBACK;
                     elapsed_in = '0;
                  end
               end
               PH_AWAIT_DONE: begin
                  if (!req_busy_req || refresh_passed) begin
                     phase_in         = PH_POWER_OFF;
                     elapsed_in       = '0;
                     rsp_power_off_in = 1'b1;
                     rsp_fault_in     = req_busy_req;
                  end
               end
               PH_FALLBACK: begin
                  if (fallback_passed) begin
                     phase_in         = PH_POWER_OFF;
                     elapsed_in       = '0;
                     rsp_power_off_in = 1'b1;
                  end
               end
               PH_POWER_OFF: begin
                  if (settle_passed && !req_busy_req) begin
                     phase_in          = PH_IDLE;
                     elapsed_in        = '0;
                     rsp_deep_sleep_in = 1'b1;
                     rsp_outcome_in    = OUT_RELEASED;
                  end else if (power_off_passed) begin
                     phase_in          = PH_IDLE;
                     elapsed_in        = '0;
                     rsp_deep_sleep_in = 1'b1;
                     rsp_outcome_in    = OUT_TIMEOUT;
                  end
               end
               default: begin
                  phase_in         = PH_POWER_OFF;
                  elapsed_in       = '0;
                  rsp_power_off_in = 1'b1;
                  rsp_fault_in     = 1'b1;
               end
            endcase
         end
         CMD_REFRESH: begin
            if (phase_ff == PH_IDLE) begin
               phase_in   = PH_AWAIT_BUSY;
               elapsed_in = '0;
            end
         end
         CMD_SLEEP: begin
            if (phase_ff != PH_IDLE) begin
               phase_in         = PH_POWER_OFF;
               elapsed_in       = '0;
               rsp_power_off_in = 1'b1;
            end
         end
         CMD_BOOT_POWER: begin
            phase_in         = PH_POWER_OFF;
            elapsed_in       = '0;
            rsp_power_off_in = 1'b1;
         end
      endcase
      rsp_phase_in = phase_in;
   end

   // state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff   <= phase_in;
            elapsed_ff <= elapsed_in;
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_phase_ff      <= rsp_phase_in;
         rsp_power_off_ff  <= rsp_power_off_in;
         rsp_deep_sleep_ff <= rsp_deep_sleep_in;
         rsp_outcome_ff    <= rsp_outcome_in;
         rsp_fault_ff      <= rsp_fault_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_phase           = rsp_phase_ff;
   assign rsp_send_power_off  = rsp_power_off_ff;
   assign rsp_send_deep_sleep = rsp_deep_sleep_ff;
   assign rsp_outcome         = rsp_outcome_ff;
   assign rsp_refresh_fault   = rsp_fault_ff;

endmodule

// ===== design/erwc_checker.sv =====
// ----------------------------------------------------------------------------
// erwc_checker
// port-level checks of the refresh wait controller, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "epaper_refresh_wait_controller_core_assert.svh"

module erwc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_phase,
   input logic       rsp_send_power_off,
   input logic       rsp_send_deep_sleep,
   input logic [1:0] rsp_outcome,
   input logic       rsp_refresh_fault
);
   import erwc_pkg::*;

   logic sleep_beat;
   logic power_off_beat;
   logic sleep_clean;

   assign sleep_beat     = rsp_valid && rsp_send_deep_sleep;
   assign power_off_beat = rsp_valid && rsp_send_power_off;
   assign sleep_clean    = rsp_outcome != OUT_NONE && rsp_phase == PH_IDLE &&
                           !rsp_send_power_off;

   // deep sleep ends the sequence and always carries an outcome
   `ERWC_ASSERT_SAME(a_sleep_ends, clock, reset, sleep_beat, sleep_clean)

   // an outcome is only reported with deep sleep
   `ERWC_ASSERT_SAME(a_outcome_sleep, clock, reset, rsp_valid && rsp_outcome != OUT_NONE, rsp_send_deep_sleep)

   // power-off always lands in the power-off wait
   `ERWC_ASSERT_SAME(a_power_off_phase, clock, reset, power_off_beat, rsp_phase == PH_POWER_OFF)

   // a refresh fault comes with the power-off command
   `ERWC_ASSERT_SAME(a_fault_power_off, clock, reset, rsp_valid && rsp_refresh_fault, rsp_send_power_off)

   // stalled result beat holds
   `ERWC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_phase) && $stable(rsp_outcome))

endmodule

bind epaper_refresh_wait_controller_core erwc_checker u_erwc_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_phase           (rsp_phase),
   .rsp_send_power_off  (rsp_send_power_off),
   .rsp_send_deep_sleep (rsp_send_deep_sleep),
   .rsp_outcome         (rsp_outcome),
   .rsp_refresh_fault   (rsp_refresh_fault)
);

// ===== tb/sv/tb_epaper_refresh_wait_controller_core.sv =====
// ----------------------------------------------------------------------------
// tb_epaper_refresh_wait_controller_core
// drives command beats (ticks with busy level, refresh start, sleep request,
// boot power-down) into the refresh wait controller and predicts the phase,
// power-off and deep-sleep strobes, outcome and fault of every result beat;
// limits are rewritten between phases, small values walk every timeout path,
// zero and all-ones cover the extremes; both sides stall at random
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_epaper_refresh_wait_controller_core;
   import erwc_pkg::*;

   localparam int IDLE_CYCLE_LIMIT = 2000;
   localparam int HOLD_CYCLES      = 200;

   localparam int STYLE_ZERO   = 0;
   localparam int STYLE_MAX    = 1;
   localparam int STYLE_SMALL  = 2;
   localparam int STYLE_WIDE   = 3;
   localparam int STYLE_MIXED  = 4;
   localparam int STYLE_RANDOM = 5;

   typedef struct packed {
      logic [2:0] phase;
      logic       off_cmd;
      logic       sleep_cmd;
      logic [1:0] outcome;
      logic       fault;
   } status_beat_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [1:0]               req_cmd = CMD_TICK;
   logic                     req_busy_req = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [2:0]               rsp_phase;
   logic                     rsp_send_power_off;
   logic                     rsp_send_deep_sleep;
   logic [1:0]               rsp_outcome;
   logic                     rsp_refresh_fault;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   epaper_refresh_wait_controller_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_busy_req        (req_busy_req),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_phase           (rsp_phase),
      .rsp_send_power_off  (rsp_send_power_off),
      .rsp_send_deep_sleep (rsp_send_deep_sleep),
      .rsp_outcome         (rsp_outcome),
      .rsp_refresh_fault   (rsp_refresh_fault),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   // predictor state
   logic [2:0]          model_phase = PH_IDLE;
   logic [CFG_BITS-1:0] model_ticks = '0;
   logic [CFG_BITS-1:0] limit_cfg [0:4];

   status_beat_type pending_status [$];
   int              error_count     = 0;
   int              idle_cycles     = 0;
   bit              gaps_on         = 1'b1;
   int              rsp_hold_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      limit_cfg[CSR_BUSY_ASSERT_LIMIT] = BUSY_ASSERT_LIMIT_RST;
      limit_cfg[CSR_REFRESH_LIMIT]     = REFRESH_LIMIT_RST;
      limit_cfg[CSR_FALLBACK_DELAY]    = FALLBACK_DELAY_RST;
      limit_cfg[CSR_POWER_OFF_SETTLE]  = POWER_OFF_SETTLE_RST;
      limit_cfg[CSR_POWER_OFF_LIMIT]   = POWER_OFF_LIMIT_RST;
   end

   function automatic void enter_phase(input logic [2:0] next);
      model_phase = next;
      model_ticks = '0;
   endfunction

   function automatic status_beat_type step_refresh_wait(input cmd_type cmd, input logic busy);
      status_beat_type s;
      s = '0;
      case (cmd)
         CMD_TICK: begin
            if (model_ticks != '1)
               model_ticks = model_ticks + 1'b1;
            case (model_phase)
               PH_IDLE: ;
               PH_AWAIT_BUSY: begin
                  if (busy)
                     enter_phase(PH_AWAIT_DONE);
                  else if (model_ticks > limit_cfg[CSR_BUSY_ASSERT_LIMIT])
                     enter_phase(PH_FALLBACK);
               end
               PH_AWAIT_DONE: begin
                  if (!busy) begin
                     enter_phase(PH_POWER_OFF);
                     s.off_cmd = 1'b1;
                  end else if (model_ticks > limit_cfg[CSR_REFRESH_LIMIT]) begin
                     enter_phase(PH_POWER_OFF);
                     s.off_cmd = 1'b1;
                     s.fault = 1'b1;
                  end
               end
               PH_FALLBACK: begin
                  if (model_ticks > limit_cfg[CSR_FALLBACK_DELAY]) begin
                     enter_phase(PH_POWER_OFF);
                     s.off_cmd = 1'b1;
                  end
               end
               PH_POWER_OFF: begin
                  if (model_ticks > limit_cfg[CSR_POWER_OFF_SETTLE] && !busy) begin
                     enter_phase(PH_IDLE);
                     s.sleep_cmd = 1'b1;
                     s.outcome = OUT_RELEASED;
                  end else if (model_ticks > limit_cfg[CSR_POWER_OFF_LIMIT]) begin
                     enter_phase(PH_IDLE);
                     s.sleep_cmd = 1'b1;
                     s.outcome = OUT_TIMEOUT;
                  end
               end
               default: begin
                  enter_phase(PH_POWER_OFF);
                  s.off_cmd = 1'b1;
                  s.fault = 1'b1;
               end
            endcase
         end
         CMD_REFRESH: begin
            if (model_phase == PH_IDLE)
               enter_phase(PH_AWAIT_BUSY);
         end
         CMD_SLEEP: begin
            if (model_phase != PH_IDLE) begin
               enter_phase(PH_POWER_OFF);
               s.off_cmd = 1'b1;
            end
         end
         default: begin
            enter_phase(PH_POWER_OFF);
            s.off_cmd = 1'b1;
         end
      endcase
      s.phase = model_phase;
      return s;
   endfunction

   function automatic bit is_noop(input cmd_type cmd);
      return (cmd == CMD_REFRESH && model_phase != PH_IDLE) ||
             (cmd == CMD_SLEEP && model_phase == PH_IDLE);
   endfunction

   function automatic int pick_gap_len();
      int r;
      r = $urandom_range(0, 19);
      if (r < 14)
         return $urandom_range(1, 2);
      else if (r < 19)
         return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_cmd(input cmd_type cmd, input logic busy);
      int gap;
      gap = (gaps_on && $urandom_range(0, 2) == 0) ? pick_gap_len() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_busy_req <= busy;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_status.push_back(step_refresh_wait(cmd, busy));
   endtask

   task automatic release_req();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_status.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CSR_IDX_BITS-1:0] idx, input logic [31:0] value);
      release_req();
      wait_drained();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      limit_cfg[idx] = value[CFG_BITS-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic logic [31:0] pick_limit(input int style);
      case (style)
         STYLE_ZERO:   return 32'd0;
         STYLE_MAX:    return 32'h03FF_FFFF;
         STYLE_SMALL:  return $urandom_range(0, 15);
         STYLE_WIDE:   return $urandom_range(0, 40);
         STYLE_MIXED: begin
            case ($urandom_range(0, 3))
               0:       return 32'd0;
               1:       return 32'h03FF_FFFF;
               default: return $urandom_range(0, 12);
            endcase
         end
         default:      return $urandom();
      endcase
   endfunction

   task automatic load_limits(input int style);
      write_limit(CSR_BUSY_ASSERT_LIMIT, pick_limit(style));
      write_limit(CSR_REFRESH_LIMIT, pick_limit(style));
      write_limit(CSR_FALLBACK_DELAY, pick_limit(style));
      write_limit(CSR_POWER_OFF_SETTLE, pick_limit(style));
      write_limit(CSR_POWER_OFF_LIMIT, pick_limit(style));
   endtask

   // mostly refresh cycles fed by ticks with a slowly toggling busy level
   task automatic run_random_walk(input int beats);
      int      counted;
      int      r;
      logic    busy;
      cmd_type cmd;
      counted = 0;
      busy = 1'b0;
      while (counted < beats) begin
         if ($urandom_range(0, 6) == 0)
            busy = ~busy;
         r = $urandom_range(0, 99);
         if (model_phase == PH_IDLE && r < 25)
            cmd = CMD_REFRESH;
         else if (r < 88)
            cmd = CMD_TICK;
         else if (r < 93)
            cmd = CMD_REFRESH;
         else if (r < 97)
            cmd = CMD_SLEEP;
         else
            cmd = CMD_BOOT_POWER;
         if (!is_noop(cmd))
            counted++;
         send_cmd(cmd, (cmd == CMD_TICK) ? busy : 1'($urandom_range(0, 1)));
      end
   endtask

   // reset limits: events move the phase, no timeout can fire
   task automatic test_event_handling();
      send_cmd(CMD_TICK, 1'b0);
      send_cmd(CMD_TICK, 1'b1);
      send_cmd(CMD_SLEEP, 1'b0);
      send_cmd(CMD_REFRESH, 1'b0);
      send_cmd(CMD_REFRESH, 1'b1);
      send_cmd(CMD_SLEEP, 1'b1);
      send_cmd(CMD_SLEEP, 1'b0);
      send_cmd(CMD_BOOT_POWER, 1'b1);
      send_cmd(CMD_TICK, 1'b1);
   endtask

   // tiny limits: fallback, refresh fault, release and timeout endings
   task automatic test_limit_expiry();
      write_limit(CSR_BUSY_ASSERT_LIMIT, 32'd1);
      write_limit(CSR_REFRESH_LIMIT, 32'd1);
      write_limit(CSR_FALLBACK_DELAY, 32'd1);
      write_limit(CSR_POWER_OFF_SETTLE, 32'd0);
      write_limit(CSR_POWER_OFF_LIMIT, 32'd2);
      send_cmd(CMD_TICK, 1'b0);
      send_cmd(CMD_REFRESH, 1'b0);
      send_cmd(CMD_TICK, 1'b0);
      send_cmd(CMD_TICK, 1'b0);
      send_cmd(CMD_TICK, 1'b1);
      send_cmd(CMD_TICK, 1'b1);
      send_cmd(CMD_TICK, 1'b1);
      send_cmd(CMD_TICK, 1'b1);
      send_cmd(CMD_TICK, 1'b1);
      send_cmd(CMD_REFRESH, 1'b1);
      send_cmd(CMD_TICK, 1'b1);
      send_cmd(CMD_TICK, 1'b1);
      send_cmd(CMD_TICK, 1'b1);
      send_cmd(CMD_TICK, 1'b0);
      send_cmd(CMD_BOOT_POWER, 1'b0);
      send_cmd(CMD_TICK, 1'b0);
   endtask

   task automatic test_random_settings();
      int style;
      int round_style [0:7];
      round_style = '{STYLE_SMALL, STYLE_ZERO, STYLE_WIDE, STYLE_MAX,
                      STYLE_MIXED, STYLE_RANDOM, STYLE_SMALL, STYLE_MIXED};
      for (int k = 0; k < 8; k++) begin
         style = round_style[k];
         load_limits(style);
         gaps_on = (k != 6);
         run_random_walk((style == STYLE_MAX || style == STYLE_RANDOM) ? 60 : 190);
      end
      gaps_on = 1'b1;
   endtask

   task automatic test_output_backpressure();
      load_limits(STYLE_SMALL);
      gaps_on = 1'b0;
      rsp_hold_cycles = HOLD_CYCLES;
      run_random_walk(40);
      gaps_on = 1'b1;
   endtask

   // result side ready pattern
   initial begin
      int len;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            len = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_ready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            len = pick_gap_len();
            rsp_ready <= 1'b0;
         end else begin
            len = $urandom_range(1, 6);
            rsp_ready <= 1'b1;
         end
         repeat (len - 1) @(negedge clock);
      end
   end

   // result checker
   always @(posedge clock) begin
      status_beat_type want;
      status_beat_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_phase, rsp_send_power_off, rsp_send_deep_sleep, rsp_outcome,
                 rsp_refresh_fault};
         if (pending_status.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("%0t: unexpected beat: ph %0d off %0b slp %0b out %0d flt %0b",
                        $realtime, got.phase, got.off_cmd, got.sleep_cmd, got.outcome,
                        got.fault);
         end else begin
            want = pending_status.pop_front();
            if (got.phase !== want.phase || got.off_cmd !== want.off_cmd ||
                got.sleep_cmd !== want.sleep_cmd || got.outcome !== want.outcome ||
                got.fault !== want.fault) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: exp %0d %0b %0b %0d %0b, got %0d %0b %0b %0d %0b",
                           $realtime, want.phase, want.off_cmd, want.sleep_cmd,
                           want.outcome, want.fault, got.phase, got.off_cmd,
                           got.sleep_cmd, got.outcome, got.fault);
            end
         end
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_CYCLE_LIMIT) begin
         $display("tb_epaper_refresh_wait_controller_core: errors");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_event_handling();
      test_limit_expiry();
      test_random_settings();
      test_output_backpressure();
      release_req();
      wait_drained();
      repeat (4) @(posedge clock);
      if (error_count == 0 && pending_status.size() == 0)
         $display("tb_epaper_refresh_wait_controller_core: clean");
      else
         $display("tb_epaper_refresh_wait_controller_core: errors");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/erwc_pkg.sv
design/epaper_refresh_wait_controller_core.sv
design/erwc_checker.sv
tb/sv/tb_epaper_refresh_wait_controller_core.sv
